// File: hdl/rhc_pkg.sv
package rhc_pkg;

	// Field widths fixed by the stream format.
	localparam int FIELD_W   = 16;
	localparam int HUE_OUT_W = 15;

	// Hue geometry in whole degrees, scaled by the fraction bits in the datapath.
	localparam int SIXTY_DEG  = 60;
	localparam int FULL_DEG   = 360;
	localparam int GREEN_MULT = 2;
	localparam int BLUE_MULT  = 4;

	// Which channel holds the maximum, and therefore the hue sector.
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	// Hue control that rides alongside the dividers.
	typedef struct packed {
		sector_t sector;
		logic    neg;
		logic    gray;
	} hue_ctl_t;

	// Input beat, red in the lowest bits.
	typedef struct packed {
		logic [FIELD_W-1:0] alpha;
		logic [FIELD_W-1:0] blue;
		logic [FIELD_W-1:0] green;
		logic [FIELD_W-1:0] red;
	} pixel_in_t;

	// Output beat, hue in the lowest bits, one spare bit on top.
	typedef struct packed {
		logic                 spare;
		logic [FIELD_W-1:0]   alpha;
		logic [FIELD_W-1:0]   bright;
		logic [FIELD_W-1:0]   sat;
		logic [HUE_OUT_W-1:0] hue;
	} pixel_out_t;

endpackage

// File: hdl/rhc_front.sv
module rhc_front #(
	parameter int CHANNEL_BITS  = 16,
	parameter int HUE_FRAC_BITS = 6,
	parameter int HUE_QUO_W     = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  ce,
	input  logic                                  in_valid,
	input  logic [CHANNEL_BITS-1:0]               red,
	input  logic [CHANNEL_BITS-1:0]               green,
	input  logic [CHANNEL_BITS-1:0]               blue,
	input  logic [rhc_pkg::FIELD_W-1:0]           alpha,
	input  logic [rhc_pkg::FIELD_W-1:0]           threshold,
	output logic                                  valid_s2,
	output logic [rhc_pkg::FIELD_W-1:0]           alpha_s2,
	output logic [CHANNEL_BITS-1:0]               bright_s2,
	output rhc_pkg::hue_ctl_t                     ctl_s2,
	output logic [2*CHANNEL_BITS-1:0]             sat_num_s2,
	output logic [CHANNEL_BITS+HUE_QUO_W-1:0]     hue_num_s2
);
	import rhc_pkg::*;

	localparam int CB        = CHANNEL_BITS;
	localparam int HUE_NUM_W = CB + HUE_QUO_W;
	localparam int CMP_W     = (CB > FIELD_W) ? CB : FIELD_W;

	logic          red_max;
	logic          green_max;
	sector_t       sector;
	logic [CB-1:0] max_val;
	logic [CB-1:0] min_val;
	logic [CB-1:0] hi_op;
	logic [CB-1:0] lo_op;

	logic              valid_s1;
	logic [FIELD_W-1:0] alpha_s1;
	logic [CB-1:0]     max_s1;
	logic [CB-1:0]     min_s1;
	sector_t           sector_s1;
	logic signed [CB:0] diff_s1;

	logic [CB-1:0]        delta;
	logic [CMP_W-1:0]     delta_c;
	logic [CMP_W-1:0]     thr_c;
	logic                 neg;
	logic signed [CB:0]   diff_abs;
	logic [CB-1:0]        mag;
	hue_ctl_t             ctl;

	// Pick the largest channel; red wins ties, then green.
	always_comb begin
		red_max   = (red >= green) && (red >= blue);
		green_max = !red_max && (green >= blue);
		if (red_max) begin
			sector  = SECT_RED;
			max_val = red;
			hi_op   = green;
			lo_op   = blue;
		end else if (green_max) begin
			sector  = SECT_GREEN;
			max_val = green;
			hi_op   = blue;
			lo_op   = red;
		end else begin
			sector  = SECT_BLUE;
			max_val = blue;
			hi_op   = red;
			lo_op   = green;
		end
		if (red <= green) begin
			min_val = (red <= blue) ? red : blue;
		end else begin
			min_val = (green <= blue) ? green : blue;
		end
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 data: extremes, sector and the signed hue numerator.
	always_ff @(posedge clk) begin
		if (ce) begin
			alpha_s1  <= alpha;
			max_s1    <= max_val;
			min_s1    <= min_val;
			sector_s1 <= sector;
			diff_s1   <= $signed({1'b0, hi_op}) - $signed({1'b0, lo_op});
		end
	end

	// Chroma, gray test and magnitude of the hue numerator.
	always_comb begin
		delta    = max_s1 - min_s1;
		delta_c  = CMP_W'(delta);
		thr_c    = CMP_W'(threshold);
		neg      = diff_s1[CB];
		diff_abs = neg ? -diff_s1 : diff_s1;
		mag      = diff_abs[CB-1:0];
		ctl.sector = sector_s1;
		ctl.neg    = neg;
		ctl.gray   = (delta == '0) || (delta_c < thr_c);
	end

	// Stage 2 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 data: the two dividends, built from shifts and one subtract each.
	always_ff @(posedge clk) begin
		if (ce) begin
			alpha_s2   <= alpha_s1;
			bright_s2  <= max_s1;
			ctl_s2     <= ctl;
			sat_num_s2 <= ((2*CB)'(delta) << CB) - (2*CB)'(delta);
			hue_num_s2 <= (HUE_NUM_W'(mag) << (HUE_FRAC_BITS + 6))
				- (HUE_NUM_W'(mag) << (HUE_FRAC_BITS + 2));
		end
	end

endmodule

// File: hdl/rhc_div_pipe.sv
module rhc_div_pipe #(
	parameter int DEN_W = 16,
	parameter int QUO_W = 16,
	parameter int DEPTH = 16
) (
	input  logic                   clk,
	input  logic                   ce,
	input  logic [DEN_W+QUO_W-1:0] num,
	input  logic [DEN_W-1:0]       den,
	output logic [QUO_W-1:0]       quo,
	output logic                   rem_nz
);

	localparam int NUM_W = DEN_W + QUO_W;

	logic [NUM_W-1:0] num_s [DEPTH];
	logic [DEN_W-1:0] den_s [DEPTH];
	logic [QUO_W-1:0] quo_s [DEPTH];

	// One restoring step per stage, most significant quotient bit first.
	// Stages past the quotient width only carry the result along.
	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		logic [NUM_W-1:0] num_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		logic [NUM_W-1:0] num_nx;
		logic [QUO_W-1:0] quo_nx;

		if (k == 0) begin : g_first
			assign num_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign num_in = num_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		if (k < QUO_W) begin : g_bit
			localparam int SH = QUO_W - 1 - k;
			logic [NUM_W-1:0] trial;

			assign trial = NUM_W'(den_in) << SH;

			always_comb begin
				num_nx = num_in;
				quo_nx = quo_in;
				if (num_in >= trial) begin
					num_nx     = num_in - trial;
					quo_nx[SH] = 1'b1;
				end
			end
		end else begin : g_pad
			assign num_nx = num_in;
			assign quo_nx = quo_in;
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				num_s[k] <= num_nx;
				den_s[k] <= den_in;
				quo_s[k] <= quo_nx;
			end
		end
	end

	assign quo    = quo_s[DEPTH-1];
	assign rem_nz = |num_s[DEPTH-1];

endmodule

// File: hdl/rhc_back.sv
module rhc_back #(
	parameter int CHANNEL_BITS  = 16,
	parameter int HUE_FRAC_BITS = 6,
	parameter int HUE_QUO_W     = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ce,
	input  logic                        in_valid,
	input  rhc_pkg::hue_ctl_t           ctl,
	input  logic [HUE_QUO_W-1:0]        hue_quo,
	input  logic                        hue_rem_nz,
	input  logic [CHANNEL_BITS-1:0]     sat_quo,
	input  logic [CHANNEL_BITS-1:0]     bright,
	input  logic [rhc_pkg::FIELD_W-1:0] alpha,
	output logic                        valid_s2,
	output rhc_pkg::pixel_out_t         res_s2
);
	import rhc_pkg::*;

	localparam int CB        = CHANNEL_BITS;
	localparam int HUE_SIXTY = SIXTY_DEG << HUE_FRAC_BITS;
	localparam int HUE_FULL  = FULL_DEG << HUE_FRAC_BITS;
	localparam int HUE_W     = $clog2(HUE_FULL) + 2;

	localparam logic signed [HUE_W-1:0] BASE_GREEN = HUE_W'(GREEN_MULT * HUE_SIXTY);
	localparam logic signed [HUE_W-1:0] BASE_BLUE  = HUE_W'(BLUE_MULT * HUE_SIXTY);
	localparam logic signed [HUE_W-1:0] FULL_H     = HUE_W'(HUE_FULL);

	logic signed [HUE_W-1:0] base;
	logic signed [HUE_W-1:0] q_ext;
	logic signed [HUE_W-1:0] q_op;
	logic signed [HUE_W-1:0] q_cin;
	logic signed [HUE_W-1:0] hue_sum;

	logic                    valid_s1;
	logic signed [HUE_W-1:0] hue_s1;
	logic                    gray_s1;
	logic [CB-1:0]           sat_s1;
	logic [CB-1:0]           bright_s1;
	logic [FIELD_W-1:0]      alpha_s1;

	logic signed [HUE_W-1:0]         hue_wrap;
	logic [HUE_W+HUE_OUT_W-1:0]      hue_x;
	logic [CB+FIELD_W-1:0]           sat_x;
	logic [CB+FIELD_W-1:0]           bright_x;
	pixel_out_t                      res;

	// Sector base plus the floored partial hue. For a negative numerator,
	// -q - (remainder != 0) is formed as ~q plus a carry in.
	always_comb begin
		unique case (ctl.sector)
			SECT_RED:   base = '0;
			SECT_GREEN: base = BASE_GREEN;
			SECT_BLUE:  base = BASE_BLUE;
			default:    base = '0;
		endcase
		q_ext   = HUE_W'(hue_quo);
		q_op    = ctl.neg ? ~q_ext : q_ext;
		q_cin   = HUE_W'(ctl.neg & ~hue_rem_nz);
		hue_sum = base + q_op + q_cin;
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 data.
	always_ff @(posedge clk) begin
		if (ce) begin
			hue_s1    <= hue_sum;
			gray_s1   <= ctl.gray;
			sat_s1    <= sat_quo;
			bright_s1 <= bright;
			alpha_s1  <= alpha;
		end
	end

	// Wrap the hue into one turn, then zero hue and saturation for gray pixels.
	always_comb begin
		if (hue_s1 < 0) begin
			hue_wrap = hue_s1 + FULL_H;
		end else if (hue_s1 >= FULL_H) begin
			hue_wrap = hue_s1 - FULL_H;
		end else begin
			hue_wrap = hue_s1;
		end
		hue_x    = {{HUE_OUT_W{1'b0}}, hue_wrap};
		sat_x    = {{FIELD_W{1'b0}}, sat_s1};
		bright_x = {{FIELD_W{1'b0}}, bright_s1};
		res.spare  = 1'b0;
		res.alpha  = alpha_s1;
		res.bright = bright_x[FIELD_W-1:0];
		res.sat    = gray_s1 ? '0 : sat_x[FIELD_W-1:0];
		res.hue    = gray_s1 ? '0 : hue_x[HUE_OUT_W-1:0];
	end

	// Stage 2 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 data.
	always_ff @(posedge clk) begin
		if (ce) begin
			res_s2 <= res;
		end
	end

endmodule

// File: hdl/rhc_out_skid.sv
module rhc_out_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  rhc_pkg::pixel_out_t in_data,
	output logic                ce,
	output logic                out_valid,
	input  logic                out_ready,
	output rhc_pkg::pixel_out_t out_data
);
	import rhc_pkg::*;

	logic       out_valid_q;
	pixel_out_t out_data_q;
	logic       skid_valid_q;
	pixel_out_t skid_data_q;

	// The pipeline moves whenever the skid register is free.
	assign ce        = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Valid flags of the output and skid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_valid) begin
			if (out_valid_q && !out_ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Beat payloads.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_data_q <= skid_data_q;
			end
		end else if (in_valid) begin
			if (out_valid_q && !out_ready) begin
				skid_data_q <= in_data;
			end else begin
				out_data_q <= in_data;
			end
		end
	end

endmodule

// File: hdl/rgb_to_hsv_convert_core.sv
// RGBA to HSV pixel converter.
//
// Input stream (s_axis): one RGBA pixel per beat, four unsigned channels.
// Output stream (m_axis): one HSV pixel per beat: hue in fractions of a degree,
// saturation, brightness (largest channel) and alpha copied through.
// cfg_wr_en / cfg_wr_data write the gray threshold; a chroma below it gives
// zero hue and saturation. It resets to 1 and should change only while idle.
//
// Throughput is one pixel per clock while the receiver keeps up. The two
// restoring dividers (saturation and hue) resolve one quotient bit per stage,
// side by side, and set the length of the pipeline.
//
// Reset clears every valid flag and the output stream goes quiet. When the
// receiver stalls, the held output beat stays put and one more beat lands in
// a skid register; the pipeline then freezes and s_axis_tready drops until
// the skid register empties. No beat is lost or repeated.
module rgb_to_hsv_convert_core #(
	parameter int CHANNEL_BITS  = 16,
	parameter int HUE_FRAC_BITS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// red_in[15:0], green_in[31:16], blue_in[47:32], alpha_in[63:48]
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// hue_out[14:0], sat_out[30:15], bright_out[46:31], alpha_out[62:47], zero[63]
	output logic [63:0] m_axis_tdata,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);
	import rhc_pkg::*;

	localparam int CB        = CHANNEL_BITS;
	localparam int HUE_QUO_W = $clog2((SIXTY_DEG << HUE_FRAC_BITS) + 1);
	localparam int DIV_DEPTH = (CB > HUE_QUO_W) ? CB : HUE_QUO_W;

	logic [FIELD_W-1:0] thr_q;
	logic               ce;

	pixel_in_t           pix;
	logic [CB+FIELD_W-1:0] red_x;
	logic [CB+FIELD_W-1:0] green_x;
	logic [CB+FIELD_W-1:0] blue_x;

	logic                  fr_valid;
	logic [FIELD_W-1:0]    fr_alpha;
	logic [CB-1:0]         fr_bright;
	hue_ctl_t              fr_ctl;
	logic [2*CB-1:0]       fr_sat_num;
	logic [CB+HUE_QUO_W-1:0] fr_hue_num;

	logic [CB-1:0]         sat_quo;
	logic                  sat_rem_nz;
	logic [HUE_QUO_W-1:0]  hue_quo;
	logic                  hue_rem_nz;

	logic                  valid_s [DIV_DEPTH];
	logic [FIELD_W-1:0]    alpha_s [DIV_DEPTH];
	logic [CB-1:0]         bright_s [DIV_DEPTH];
	hue_ctl_t              ctl_s [DIV_DEPTH];

	logic                  bk_valid;
	pixel_out_t            bk_res;
	pixel_out_t            out_res;

	// Gray threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= FIELD_W'(1);
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// Keep the low channel bits of each color.
	assign pix     = pixel_in_t'(s_axis_tdata);
	assign red_x   = {{CB{1'b0}}, pix.red};
	assign green_x = {{CB{1'b0}}, pix.green};
	assign blue_x  = {{CB{1'b0}}, pix.blue};
	assign s_axis_tready = ce;

	rhc_front #(
		.CHANNEL_BITS (CHANNEL_BITS),
		.HUE_FRAC_BITS(HUE_FRAC_BITS),
		.HUE_QUO_W    (HUE_QUO_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (s_axis_tvalid),
		.red       (red_x[CB-1:0]),
		.green     (green_x[CB-1:0]),
		.blue      (blue_x[CB-1:0]),
		.alpha     (pix.alpha),
		.threshold (thr_q),
		.valid_s2  (fr_valid),
		.alpha_s2  (fr_alpha),
		.bright_s2 (fr_bright),
		.ctl_s2    (fr_ctl),
		.sat_num_s2(fr_sat_num),
		.hue_num_s2(fr_hue_num)
	);

	// Saturation: delta * full scale / max.
	rhc_div_pipe #(
		.DEN_W(CB),
		.QUO_W(CB),
		.DEPTH(DIV_DEPTH)
	) u_sat_div (
		.clk   (clk),
		.ce    (ce),
		.num   (fr_sat_num),
		.den   (fr_bright),
		.quo   (sat_quo),
		.rem_nz(sat_rem_nz)
	);

	// Hue offset inside the sector: 60 degrees * |numerator| / delta.
	// The saturation dividend is delta * full scale, so its upper half is
	// delta - 1 and its lower half is nonzero whenever delta is.
	rhc_div_pipe #(
		.DEN_W(CB),
		.QUO_W(HUE_QUO_W),
		.DEPTH(DIV_DEPTH)
	) u_hue_div (
		.clk   (clk),
		.ce    (ce),
		.num   (fr_hue_num),
		.den   (fr_sat_num[2*CB-1:CB] + CB'(|fr_sat_num[CB-1:0])),
		.quo   (hue_quo),
		.rem_nz(hue_rem_nz)
	);

	// Control and pass-through fields keep pace with the dividers.
	for (genvar k = 0; k < DIV_DEPTH; k++) begin : g_side
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else if (ce) begin
					valid_s[k] <= fr_valid;
				end
			end
			always_ff @(posedge clk) begin
				if (ce) begin
					alpha_s[k]  <= fr_alpha;
					bright_s[k] <= fr_bright;
					ctl_s[k]    <= fr_ctl;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else if (ce) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
			always_ff @(posedge clk) begin
				if (ce) begin
					alpha_s[k]  <= alpha_s[k-1];
					bright_s[k] <= bright_s[k-1];
					ctl_s[k]    <= ctl_s[k-1];
				end
			end
		end
	end

	rhc_back #(
		.CHANNEL_BITS (CHANNEL_BITS),
		.HUE_FRAC_BITS(HUE_FRAC_BITS),
		.HUE_QUO_W    (HUE_QUO_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (valid_s[DIV_DEPTH-1]),
		.ctl       (ctl_s[DIV_DEPTH-1]),
		.hue_quo   (hue_quo),
		.hue_rem_nz(hue_rem_nz),
		.sat_quo   (sat_quo),
		.bright    (bright_s[DIV_DEPTH-1]),
		.alpha     (alpha_s[DIV_DEPTH-1]),
		.valid_s2  (bk_valid),
		.res_s2    (bk_res)
	);

	rhc_out_skid u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bk_valid & ~sat_rem_nz | bk_valid),
		.in_data  (bk_res),
		.ce       (ce),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (out_res)
	);

	assign m_axis_tdata = 64'(out_res);

endmodule

// File: hdl/rhc_checker.sv
module rhc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);
	import rhc_pkg::*;

	pixel_out_t res;

	assign res = pixel_out_t'(m_axis_tdata);

	// A stalled output beat holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// Input back-pressure only follows a stall on the output side.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without an output stall");

	// A black pixel has no chroma, so hue and saturation are zero.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (res.bright == '0) |-> (res.hue == '0) && (res.sat == '0))
		else $error("black pixel with hue or saturation");

	// Any pixel with a nonzero hue has a nonzero saturation.
	a_hue_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (res.hue != '0) |-> (res.sat != '0))
		else $error("nonzero hue with zero saturation");

endmodule

bind rgb_to_hsv_convert_core rhc_checker u_rhc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
